[sv/mfld_pkg.sv]
// Shared types and constants for the mono frame buffer line draw engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mfld_pkg;

  // Default frame geometry
  localparam int DEF_FRAME_WIDTH  = 200;
  localparam int DEF_FRAME_HEIGHT = 200;

  // Pixel and byte constants
  localparam logic [7:0] PIX_MSB  = 8'h80;  // leftmost pixel of a byte
  localparam logic [2:0] BIT_MASK = 3'h7;   // pixel position within a byte
  localparam logic [7:0] WHITE    = 8'hFF;  // eight white pixels

  // Operation codes; six and seven are unused
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_HLINE = 3'd1,
    OP_VLINE = 3'd2,
    OP_RECT  = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SEG_SORT,
    ST_SEG_CLIP,
    ST_SEG_ADDR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_ACCESS,
    ST_FINISH
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_cmd;    // capture an accepted word
    logic seg_first;    // start at the first segment
    logic seg_next;     // move to the next segment
    logic seg_sort;     // order the segment ends
    logic seg_clip;     // clamp the segment to the frame
    logic seg_addr;     // compute start address and run length
    logic clr_start;    // reset the sweep address
    logic clr_step;     // write white and advance the sweep
    logic pix_rd;       // read the byte under the run
    logic pix_wr;       // write back the byte with pixels blackened
    logic pix_adv;      // step to the next byte of the run
    logic byte_acc;     // single byte write or read by index
    logic load_result;  // load the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       seg_last;
    logic       seg_vis;
    logic       run_last;
    logic       clr_last;
  } status_t;

endpackage

`default_nettype wire

[sv/mfld_ctrl.sv]
// Controller state machine for the mono frame buffer line draw engine.
// Depends on mfld_pkg; drives mfld_datapath through cmd_t and reads status_t.
`default_nettype none

module mfld_ctrl
  import mfld_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  ctrl_state_t state, state_next;
  logic        report, report_next;
  logic        out_valid_next;

  // State, report flag and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      report    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      report    <= report_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    logic seg_done;
    state_next     = state;
    report_next    = report;
    cmd            = '0;
    seg_done       = 1'b0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;

    unique case (state)
      ST_INIT: begin
        cmd.clr_start = 1'b1;
        state_next    = ST_CLEAR;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_cmd = in_valid;
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.op) inside
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            report_next   = 1'b1;
            state_next    = ST_CLEAR;
          end
          OP_HLINE, OP_VLINE, OP_RECT: begin
            cmd.seg_first = 1'b1;
            state_next    = ST_SEG_SORT;
          end
          OP_WRITE, OP_READ: state_next = ST_ACCESS;
          default:           state_next = ST_FINISH;
        endcase
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = report ? ST_FINISH : ST_IDLE;
      end
      ST_SEG_SORT: begin
        cmd.seg_sort = 1'b1;
        state_next   = ST_SEG_CLIP;
      end
      ST_SEG_CLIP: begin
        cmd.seg_clip = 1'b1;
        state_next   = ST_SEG_ADDR;
      end
      ST_SEG_ADDR: begin
        cmd.seg_addr = 1'b1;
        if (sts.seg_vis) state_next = ST_PIX_RD;
        else             seg_done   = 1'b1;
      end
      ST_PIX_RD: begin
        cmd.pix_rd = 1'b1;
        state_next = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        if (sts.run_last) begin
          seg_done = 1'b1;
        end else begin
          cmd.pix_adv = 1'b1;
          state_next  = ST_PIX_RD;
        end
      end
      ST_ACCESS: begin
        cmd.byte_acc = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold the result until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase

    // Advance to the next segment or finish the command
    if (seg_done) begin
      if (sts.seg_last) begin
        state_next = ST_FINISH;
      end else begin
        cmd.seg_next = 1'b1;
        state_next   = ST_SEG_SORT;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting word");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_PIX_WR |-> $past(state) == ST_PIX_RD)
    else $error("write-back without a preceding read");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_DECODE)
    else $error("accepted word not decoded");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.pix_wr, cmd.clr_step, cmd.byte_acc, cmd.pix_rd}))
    else $error("two store accesses in one cycle");
`endif

endmodule

`default_nettype wire

[sv/mfld_datapath.sv]
// Datapath for the mono frame buffer line draw engine: frame store, segment
// clipping, run address generation and result register. Depends on mfld_pkg.
`default_nettype none

module mfld_datapath
  import mfld_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  wire logic               clk,
  input  wire cmd_t               cmd,
  output status_t                 sts,
  input  wire logic        [2:0]  operation,
  input  wire logic signed [15:0] first_x,
  input  wire logic signed [15:0] first_y,
  input  wire logic signed [15:0] second_x,
  input  wire logic signed [15:0] second_y,
  input  wire logic        [12:0] byte_index,
  input  wire logic        [7:0]  byte_value,
  output logic             [7:0]  read_data,
  output logic                    status
);

  localparam int BYTES_PER_ROW = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = BYTES_PER_ROW * FRAME_HEIGHT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int MAX_DIM     = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int CW          = $clog2(MAX_DIM);
  localparam logic signed [16:0] W_MAX = 17'(FRAME_WIDTH - 1);
  localparam logic signed [16:0] H_MAX = 17'(FRAME_HEIGHT - 1);

  // Command registers
  logic        [2:0]  op_q;
  logic signed [15:0] x0, y0, x1, y1;
  logic        [12:0] idx_q;
  logic        [7:0]  val_q;
  logic               idx_bad;

  // Segment registers
  logic        [1:0]  seg;
  logic               is_h;
  logic signed [15:0] lo_s, hi_s, fix_s;
  logic        [CW-1:0] lo_c, hi_c, fix_c;
  logic               vis;

  // Run registers
  logic [AW-1:0] addr;
  logic [CW-1:0] cb;
  logic [CW-1:0] remaining;

  // Store
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr, idx_addr;
  logic [7:0]    mem_wdata;
  logic [31:0]   idx_ext;

  // Capture an accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch_cmd) begin
      op_q  <= operation;
      x0    <= first_x;
      y0    <= first_y;
      x1    <= second_x;
      y1    <= second_y;
      idx_q <= byte_index;
      val_q <= byte_value;
    end
  end

  assign idx_ext  = 32'(idx_q);
  assign idx_bad  = idx_ext >= 32'(STORE_BYTES);
  assign idx_addr = idx_ext[AW-1:0];

  // Select the ends of the current segment
  logic               seg_is_h;
  logic signed [15:0] seg_fix, seg_a, seg_b;

  always_comb begin
    seg_is_h = (op_q == OP_HLINE) || (op_q == OP_RECT && !seg[1]);
    if (op_q == OP_RECT) begin
      case (seg)
        2'd0:    seg_fix = y0;
        2'd1:    seg_fix = y1;
        2'd2:    seg_fix = x0;
        default: seg_fix = x1;
      endcase
    end else begin
      seg_fix = seg_is_h ? y0 : x0;
    end
    seg_a = seg_is_h ? x0 : y0;
    seg_b = seg_is_h ? x1 : y1;
  end

  // Clip limits along and across the segment
  logic signed [16:0] lim_max, fix_max;
  assign lim_max = is_h ? W_MAX : H_MAX;
  assign fix_max = is_h ? H_MAX : W_MAX;

  // Start address of the run
  logic [CW-1:0] row, col;
  assign row = is_h ? fix_c : lo_c;
  assign col = is_h ? (lo_c >> 3) : (fix_c >> 3);

  // Segment sort, clip and run setup
  always_ff @(posedge clk) begin
    if (cmd.seg_first) seg <= 2'd0;
    if (cmd.seg_next)  seg <= seg + 2'd1;
    if (cmd.seg_sort) begin
      is_h  <= seg_is_h;
      fix_s <= seg_fix;
      lo_s  <= (seg_a < seg_b) ? seg_a : seg_b;
      hi_s  <= (seg_a < seg_b) ? seg_b : seg_a;
    end
    if (cmd.seg_clip) begin
      vis   <= !hi_s[15] && ($signed({lo_s[15], lo_s}) <= lim_max)
               && !fix_s[15] && ({fix_s[15], fix_s} <= fix_max);
      lo_c  <= lo_s[15] ? '0 : lo_s[CW-1:0];
      hi_c  <= ({hi_s[15], hi_s} > lim_max) ? lim_max[CW-1:0] : hi_s[CW-1:0];
      fix_c <= fix_s[CW-1:0];
    end
    if (cmd.seg_addr) begin
      addr      <= AW'(32'(row) * BYTES_PER_ROW + 32'(col));
      cb        <= lo_c >> 3;
      remaining <= is_h ? ((hi_c >> 3) - (lo_c >> 3)) : (hi_c - lo_c);
    end
    if (cmd.pix_adv) begin
      addr      <= is_h ? addr + AW'(1) : addr + AW'(BYTES_PER_ROW);
      cb        <= cb + CW'(1);
      remaining <= remaining - CW'(1);
    end
    // Sweep address for clear
    if (cmd.clr_start) addr <= '0;
    if (cmd.clr_step)  addr <= addr + AW'(1);
  end

  // Pixels of the current byte to blacken
  logic [2:0] first_bit, last_bit;
  logic [7:0] mask;

  always_comb begin
    first_bit = (cb == (lo_c >> 3)) ? lo_c[2:0] : 3'd0;
    last_bit  = (cb == (hi_c >> 3)) ? hi_c[2:0] : BIT_MASK;
    if (is_h) mask = (WHITE >> first_bit) & (WHITE << (BIT_MASK - last_bit));
    else      mask = PIX_MSB >> (fix_c[2:0] & BIT_MASK);
  end

  // Store port control
  always_comb begin
    mem_we    = cmd.clr_step || cmd.pix_wr
                || (cmd.byte_acc && op_q == OP_WRITE && !idx_bad);
    mem_re    = cmd.pix_rd || (cmd.byte_acc && op_q == OP_READ && !idx_bad);
    mem_addr  = cmd.byte_acc ? idx_addr : addr;
    if (cmd.clr_step)    mem_wdata = WHITE;
    else if (cmd.pix_wr) mem_wdata = rdata & ~mask;
    else                 mem_wdata = val_q;
  end

  // Frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      read_data <= (op_q == OP_READ && !idx_bad) ? rdata : 8'd0;
      status    <= (op_q == OP_READ || op_q == OP_WRITE) && idx_bad;
    end
  end

  // Status toward the controller
  assign sts.op       = op_q;
  assign sts.seg_last = (op_q == OP_RECT) ? (seg == 2'd3) : 1'b1;
  assign sts.seg_vis  = vis;
  assign sts.run_last = remaining == '0;
  assign sts.clr_last = addr == AW'(STORE_BYTES - 1);

endmodule

`default_nettype wire

[sv/mono_framebuffer_line_draw.sv]
// A rect is drawn as four segments; each segment, and an hline or vline, is sorted, clipped
// and addressed, then covered byte by byte or row by row. One command at a time: the
// read-modify-write of each covered store byte sets the rate, and a finished result
// waits in the output register while the next command is accepted. After reset a
// clearing pass writes white to the whole store with in_ready low. Uses mfld_ctrl/datapath.
`default_nettype none

module mono_framebuffer_line_draw
  import mfld_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [2:0]  operation,
  input  wire logic signed [15:0] first_x,
  input  wire logic signed [15:0] first_y,
  input  wire logic signed [15:0] second_x,
  input  wire logic signed [15:0] second_y,
  input  wire logic        [12:0] byte_index,
  input  wire logic        [7:0]  byte_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [7:0]  read_data,
  output logic                    status
);

  cmd_t    cmd;
  status_t sts;

  // Sequence the commands
  mfld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store and drawing datapath
  mfld_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (operation),
    .first_x    (first_x),
    .first_y    (first_y),
    .second_x   (second_x),
    .second_y   (second_y),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .read_data  (read_data),
    .status     (status)
  );

endmodule

`default_nettype wire

[dv/mfld_checker.sv]
// Result checker for the mono frame buffer line draw engine: keeps its own frame
// store, predicts each command's result and compares it with what comes out.
// Depends on mfld_pkg for the operation codes and the pixel constants.

module mfld_checker
  import mfld_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [2:0]  operation,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic        [12:0] byte_index,
  input  logic        [7:0]  byte_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [7:0]  read_data,
  input  logic               status,
  output int                 mismatches,
  output int                 pending
);

  localparam int BYTES_PER_ROW = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = BYTES_PER_ROW * FRAME_HEIGHT;

  typedef struct {
    logic [2:0] op_code;
    logic [7:0] data;
    logic       beyond;
  } draw_result_t;

  logic [7:0]   pixels [STORE_BYTES];
  draw_result_t results_due [$];
  int           error_count = 0;
  int           outstanding = 0;
  int           result_serial = 0;

  assign mismatches = error_count;
  assign pending    = outstanding;

  // Print one line per mismatch and count it
  task automatic report(input string what, input int got, input int want);
    error_count++;
    $display("%0t: result %0d (op %0d) %s: got %0h, want %0h", $time, result_serial,
             results_due.size() > 0 ? results_due[0].op_code : 3'd0, what, got, want);
  endtask

  // Blacken one pixel; skip anything outside the frame
  function automatic void blacken(int x, int y);
    int addr;
    if (x < 0 || x >= FRAME_WIDTH || y < 0 || y >= FRAME_HEIGHT) return;
    addr = y * BYTES_PER_ROW + (x >>> 3);
    pixels[addr] = pixels[addr] & ~(PIX_MSB >> (x[2:0] & BIT_MASK));
  endfunction

  // Horizontal run on row y between two x ends, in either order
  function automatic void draw_row(int y, int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (y < 0 || y >= FRAME_HEIGHT) return;
    if (lo < 0) lo = 0;
    if (hi > FRAME_WIDTH - 1) hi = FRAME_WIDTH - 1;
    for (int x = lo; x <= hi; x++) blacken(x, y);
  endfunction

  // Vertical run on column x between two y ends, in either order
  function automatic void draw_column(int x, int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (x < 0 || x >= FRAME_WIDTH) return;
    if (lo < 0) lo = 0;
    if (hi > FRAME_HEIGHT - 1) hi = FRAME_HEIGHT - 1;
    for (int y = lo; y <= hi; y++) blacken(x, y);
  endfunction

  // Apply one command to the frame copy and return the result it must give
  function automatic draw_result_t apply_command(logic [2:0] code, int x0, int y0,
                                                 int x1, int y1, int idx,
                                                 logic [7:0] val);
    draw_result_t res;
    res.op_code = code;
    res.data    = 8'h00;
    res.beyond  = 1'b0;
    case (code)
      OP_CLEAR: for (int i = 0; i < STORE_BYTES; i++) pixels[i] = WHITE;
      OP_HLINE: draw_row(y0, x0, x1);
      OP_VLINE: draw_column(x0, y0, y1);
      OP_RECT: begin
        draw_row(y0, x0, x1);
        draw_row(y1, x0, x1);
        draw_column(x0, y0, y1);
        draw_column(x1, y0, y1);
      end
      OP_WRITE: begin
        if (idx < STORE_BYTES) pixels[idx] = val;
        else res.beyond = 1'b1;
      end
      OP_READ: begin
        if (idx < STORE_BYTES) res.data = pixels[idx];
        else res.beyond = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Watch both channels; retire results before queueing the new command
  always @(posedge clk) begin : watch
    draw_result_t head;
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) pixels[i] = WHITE;
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report("result with nothing expected, read_data", read_data, 0);
        end else begin
          if (read_data !== results_due[0].data)
            report("read_data", read_data, results_due[0].data);
          if (status !== results_due[0].beyond)
            report("status", status, results_due[0].beyond);
          head = results_due.pop_front();
        end
        result_serial++;
      end
      if (in_valid && in_ready)
        results_due.push_back(apply_command(operation, int'(first_x), int'(first_y),
                                            int'(second_x), int'(second_y),
                                            int'(byte_index), byte_value));
    end
    outstanding = results_due.size();
  end

endmodule

[dv/tb_mono_framebuffer_line_draw.sv]
// Testbench top for the mono frame buffer line draw engine: drives directed and
// random draw, clear and byte commands with random idling on both channels.
// Depends on mfld_pkg, mono_framebuffer_line_draw and mfld_checker.

module tb_mono_framebuffer_line_draw;
  import mfld_pkg::*;

  localparam int FRAME_WIDTH   = DEF_FRAME_WIDTH;
  localparam int FRAME_HEIGHT  = DEF_FRAME_HEIGHT;
  localparam int BYTES_PER_ROW = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = BYTES_PER_ROW * FRAME_HEIGHT;
  localparam int DIRECTED      = 25;
  localparam int RANDOM_WORDS  = 450;
  localparam int QUIET_TAIL    = 50;
  localparam int MAX_CLEARS    = 4;
  localparam int TIME_LIMIT    = 4_000_000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic        [2:0]  operation;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic        [12:0] byte_index;
  logic        [7:0]  byte_value;
  logic               out_valid;
  logic               out_ready;
  logic        [7:0]  read_data;
  logic               status;
  int                 mismatches;
  int                 pending;

  logic in_fire = 1'b0;
  bit   quiet = 1'b0;
  int   gap_pct = 25;
  int   n_words = 0;
  int   n_draws = 0;
  int   n_writes = 0;
  int   n_reads = 0;
  int   n_clears = 0;
  int   n_spare = 0;

  mono_framebuffer_line_draw #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status)
  );

  mfld_checker #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) result_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note each accepted command word for the driver at the next falling edge
  always @(posedge clk) in_fire <= in_valid && in_ready;

  // Stall the result channel in bursts; hold it open in the quiet tail
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // End the run if it hangs
  initial begin
    #TIME_LIMIT;
    $display("mono_framebuffer_line_draw regression: fail");
    $finish;
  end

  // Coordinate near the frame most of the time, anywhere in 16 bits otherwise
  function automatic int coord(input int extent);
    logic signed [15:0] raw;
    raw = 16'($urandom);
    if ($urandom_range(0, 9) == 0) return int'(raw);
    return int'($urandom_range(0, extent + 39)) - 20;
  endfunction

  function automatic int fit(input int v, input int top);
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  // Byte index inside the store, now and then anywhere in 13 bits
  function automatic int rnd_index();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 8191));
    return int'($urandom_range(0, STORE_BYTES - 1));
  endfunction

  // Present one command word, after an optional idle burst, and hold it until taken
  task automatic issue(input logic [2:0] code, input int x0, input int y0, input int x1,
                       input int y1, input int idx, input int val);
    if (n_words % 32 == 0) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 60;
      endcase
    end
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= code;
    first_x    <= x0[15:0];
    first_y    <= y0[15:0];
    second_x   <= x1[15:0];
    second_y   <= y1[15:0];
    byte_index <= idx[12:0];
    byte_value <= val[7:0];
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    n_words++;
    case (code) inside
      OP_CLEAR: n_clears++;
      OP_HLINE, OP_VLINE, OP_RECT: n_draws++;
      OP_WRITE: n_writes++;
      OP_READ: n_reads++;
      default: n_spare++;
    endcase
  endtask

  // Reset, directed words, random words, drain and verdict
  initial begin
    logic [2:0] code;
    int         x0, y0, x1, y1;
    int         xa, xb, ya, yb;
    int         px, py, idx, pick;
    int         clears_left;
    bit         drained_mid;
    clears_left = MAX_CLEARS;
    drained_mid = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_CLEAR;
    first_x    = '0;
    first_y    = '0;
    second_x   = '0;
    second_y   = '0;
    byte_index = '0;
    byte_value = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: store ends, index beyond store, clipping, reversed ends, spare codes
    issue(OP_READ, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, STORE_BYTES - 1, 0);
    issue(OP_READ, 0, 0, 0, 0, STORE_BYTES, 0);
    issue(OP_WRITE, 0, 0, 0, 0, 8191, 8'h00);
    issue(OP_WRITE, 0, 0, 0, 0, 0, 8'h5A);
    issue(OP_HLINE, FRAME_WIDTH - 1, 0, -40, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0);
    issue(OP_HLINE, -32768, FRAME_HEIGHT - 1, 32767, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, STORE_BYTES - 1, 0);
    issue(OP_HLINE, 0, -1, FRAME_WIDTH - 1, 0, 0, 0);
    issue(OP_HLINE, 0, FRAME_HEIGHT, FRAME_WIDTH - 1, 0, 0, 0);
    issue(OP_VLINE, FRAME_WIDTH - 1, 300, 0, -5, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 5 * BYTES_PER_ROW + BYTES_PER_ROW - 1, 0);
    issue(OP_VLINE, FRAME_WIDTH, 0, 0, FRAME_HEIGHT - 1, 0, 0);
    issue(OP_VLINE, -32768, -32768, 32767, 32767, 8191, 8'hFF);
    issue(OP_RECT, 30, 40, 9, 12, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 12 * BYTES_PER_ROW + 1, 0);
    issue(OP_RECT, 50, 50, 50, 50, 0, 0);
    issue(OP_RECT, -10, -10, 250, 120, 0, 0);
    issue(OP_SPARE_A, -1, -1, -1, -1, 8191, 8'hFF);
    issue(OP_SPARE_B, 32767, -32768, 32767, -32768, 4096, 8'hAA);
    issue(OP_WRITE, 0, 0, 0, 0, STORE_BYTES - 1, 8'hFF);
    issue(OP_READ, 0, 0, 0, 0, STORE_BYTES - 1, 0);
    issue(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 12 * BYTES_PER_ROW + 1, 0);

    // Hold off until the directed results are all back
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);

    while (n_words < DIRECTED + RANDOM_WORDS) begin
      quiet = (n_words >= DIRECTED + RANDOM_WORDS - QUIET_TAIL);
      if (!drained_mid && n_words >= DIRECTED + RANDOM_WORDS / 2) begin
        drained_mid = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Draw a shape, then read back bytes that lie on it
        case ($urandom_range(0, 2))
          0: code = OP_HLINE;
          1: code = OP_VLINE;
          default: code = OP_RECT;
        endcase
        x0 = coord(FRAME_WIDTH);
        y0 = coord(FRAME_HEIGHT);
        x1 = coord(FRAME_WIDTH);
        y1 = coord(FRAME_HEIGHT);
        issue(code, x0, y0, x1, y1, rnd_index(), $urandom_range(0, 255));
        repeat ($urandom_range(2, 5)) begin
          xa = x0;
          xb = x1;
          ya = y0;
          yb = y1;
          case (code)
            OP_HLINE: yb = y0;
            OP_VLINE: xb = x0;
            default: begin
              case ($urandom_range(0, 3))
                0: yb = y0;
                1: ya = y1;
                2: xb = x0;
                default: xa = x1;
              endcase
            end
          endcase
          px = $urandom_range(fit(xa > xb ? xa : xb, FRAME_WIDTH - 1),
                              fit(xa < xb ? xa : xb, FRAME_WIDTH - 1));
          py = $urandom_range(fit(ya > yb ? ya : yb, FRAME_HEIGHT - 1),
                              fit(ya < yb ? ya : yb, FRAME_HEIGHT - 1));
          issue(OP_READ, $urandom, $urandom, $urandom, $urandom,
                py * BYTES_PER_ROW + px / 8, $urandom);
        end
      end else if (pick < 55) begin
        // Load a byte and read it straight back
        idx = rnd_index();
        issue(OP_WRITE, $urandom, $urandom, $urandom, $urandom, idx, $urandom_range(0, 255));
        issue(OP_READ, $urandom, $urandom, $urandom, $urandom, idx, $urandom);
      end else if (pick < 78) begin
        issue(OP_READ, $urandom, $urandom, $urandom, $urandom, rnd_index(), $urandom);
      end else if (pick < 92) begin
        issue(OP_WRITE, $urandom, $urandom, $urandom, $urandom, rnd_index(),
              $urandom_range(0, 255));
      end else if (pick < 96) begin
        issue(($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 98 && clears_left > 0) begin
        clears_left--;
        issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        issue(OP_READ, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(STORE_BYTES, 8191), $urandom);
      end
    end

    // Drain the results and give a stray one time to show up
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("covered %0d words: %0d draws, %0d byte writes, %0d byte reads, %0d clears",
             n_words, n_draws, n_writes, n_reads, n_clears);
    $display("plus %0d unused op codes on a %0dx%0d frame; %0d mismatches",
             n_spare, FRAME_WIDTH, FRAME_HEIGHT, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("mono_framebuffer_line_draw regression: pass");
    end else begin
      $display("mono_framebuffer_line_draw regression: fail");
    end
    $finish;
  end

endmodule
